### rtl/core/rti_pkg.sv
// Shared constants, types and helper functions of the ray/triangle intersector.
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

    // Default field widths
    localparam int COORD_WIDTH_DEF = 20;
    localparam int UV_WIDTH_DEF    = 16;

    // Configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int VTX_REG_W   = 60;
    localparam int TEX_AB_W    = 64;
    localparam int TEX_C_W     = 32;

    // Fixed-point formats
    localparam int PROD_SHIFT  = 12;
    localparam int T_FRAC      = 16;
    localparam int T_WIDTH     = 32;
    localparam int Q_WIDTH     = 32;
    localparam int WEIGHT_FRAC = 30;
    localparam int W_SHIFT     = Q_WIDTH - WEIGHT_FRAC;
    localparam int WA_WIDTH    = WEIGHT_FRAC + 1;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VERTEX_A,
        CFG_VERTEX_B,
        CFG_VERTEX_C,
        CFG_NORMAL_A,
        CFG_NORMAL_B,
        CFG_NORMAL_C,
        CFG_TEXCOORD_AB,
        CFG_TEXCOORD_C
    } t_cfg_index;

    // Flags that travel with each word down the pipe
    typedef struct packed {
        logic valid;
        logic hit;
        logic sat;
    } t_stage_ctl;

    // Width of the determinant and numerator sums for a given coordinate width
    function automatic int dot_width(input int cw);
        return 3 * cw + 6 - PROD_SHIFT;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rti_front.sv
// Front pipeline: edges, cross products, dot products, sign fix and hit test.
`timescale 1ns / 1ps
`default_nettype none

module rti_front #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_adv,
    input  wire logic                         i_valid,
    input  wire logic signed [COORD_WIDTH-1:0] i_o  [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_d  [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_va [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_vb [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_vc [3],
    output rti_pkg::t_stage_ctl               o_ctl,
    output logic [rti_pkg::dot_width(COORD_WIDTH)-1:0] o_den,
    output logic [rti_pkg::dot_width(COORD_WIDTH)-1:0] o_rem [3],
    output logic [rti_pkg::Q_WIDTH-1:0]       o_quo [3],
    output logic signed [COORD_WIDTH-1:0]     o_o [3],
    output logic signed [COORD_WIDTH-1:0]     o_d [3]
);

    localparam int CW  = COORD_WIDTH;
    localparam int EW  = CW + 1;
    localparam int PAW = CW + EW;
    localparam int PBW = 2 * EW;
    localparam int S1W = 2 * CW + 2 - rti_pkg::PROD_SHIFT;
    localparam int S2W = 2 * CW + 3 - rti_pkg::PROD_SHIFT;
    localparam int PW  = S2W + EW;
    localparam int DW  = rti_pkg::dot_width(COORD_WIDTH);
    localparam int TF  = rti_pkg::T_FRAC;
    localparam int QW  = rti_pkg::Q_WIDTH;

    // stage 0: edges and origin offset
    logic                 r0_valid;
    logic signed [CW-1:0] r0_o [3], r0_d [3];
    logic signed [EW-1:0] r0_e1 [3], r0_e2 [3], r0_s [3];

    // stage 1: cross-product terms
    logic                  r1_valid;
    logic signed [CW-1:0]  r1_o [3], r1_d [3];
    logic signed [EW-1:0]  r1_e1 [3], r1_e2 [3], r1_s [3];
    logic signed [PAW-1:0] r1_pa [3], r1_pb [3];
    logic signed [PBW-1:0] r1_qa [3], r1_qb [3];

    // stage 2: S1 = D x E2, S2 = S x E1
    logic                  r2_valid;
    logic signed [CW-1:0]  r2_o [3], r2_d [3];
    logic signed [EW-1:0]  r2_e1 [3], r2_e2 [3], r2_s [3];
    logic signed [S1W-1:0] r2_s1 [3];
    logic signed [S2W-1:0] r2_s2 [3];
    logic signed [PAW:0]   w_s1d [3];
    logic signed [PBW:0]   w_s2d [3];

    // stage 3: dot-product terms
    logic                 r3_valid;
    logic signed [CW-1:0] r3_o [3], r3_d [3];
    logic signed [PW-1:0] r3_det [3], r3_nt [3], r3_nb [3], r3_ng [3];

    // stage 4: sums
    logic                 r4_valid;
    logic signed [CW-1:0] r4_o [3], r4_d [3];
    logic signed [DW-1:0] r4_det, r4_nt, r4_nb, r4_ng;

    // stage 5: back faces folded onto front faces
    logic                 r5_valid;
    logic signed [CW-1:0] r5_o [3], r5_d [3];
    logic signed [DW-1:0] r5_det, r5_nt, r5_nb, r5_ng;
    logic                 w_neg;

    // stage 6: hit and saturation flags
    rti_pkg::t_stage_ctl  r6_ctl;
    logic signed [CW-1:0] r6_o [3], r6_d [3];
    logic [DW-1:0]        r6_det, r6_nt, r6_nb, r6_ng;
    logic signed [DW:0]   w_bg_sum;
    logic                 w_hit, w_sat, w_live;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_ctl   <= '0;
        end else if (i_adv) begin
            r0_valid   <= i_valid;
            r1_valid   <= r0_valid;
            r2_valid   <= r1_valid;
            r3_valid   <= r2_valid;
            r4_valid   <= r3_valid;
            r5_valid   <= r4_valid;
            r6_ctl.valid <= r5_valid;
            r6_ctl.hit   <= w_hit;
            r6_ctl.sat   <= w_sat;
        end
    end

    // stage 0
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r0_o[i]  <= i_o[i];
                r0_d[i]  <= i_d[i];
                r0_e1[i] <= EW'(i_vb[i]) - EW'(i_va[i]);
                r0_e2[i] <= EW'(i_vc[i]) - EW'(i_va[i]);
                r0_s[i]  <= EW'(i_o[i]) - EW'(i_va[i]);
            end
        end
    end

    // stage 1: the six products of each cross product
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_o  <= r0_o;
            r1_d  <= r0_d;
            r1_e1 <= r0_e1;
            r1_e2 <= r0_e2;
            r1_s  <= r0_s;
            r1_pa[0] <= r0_d[1] * r0_e2[2];
            r1_pb[0] <= r0_d[2] * r0_e2[1];
            r1_pa[1] <= r0_d[2] * r0_e2[0];
            r1_pb[1] <= r0_d[0] * r0_e2[2];
            r1_pa[2] <= r0_d[0] * r0_e2[1];
            r1_pb[2] <= r0_d[1] * r0_e2[0];
            r1_qa[0] <= r0_s[1] * r0_e1[2];
            r1_qb[0] <= r0_s[2] * r0_e1[1];
            r1_qa[1] <= r0_s[2] * r0_e1[0];
            r1_qb[1] <= r0_s[0] * r0_e1[2];
            r1_qa[2] <= r0_s[0] * r0_e1[1];
            r1_qb[2] <= r0_s[1] * r0_e1[0];
        end
    end

    // stage 2: differences floored back to Q.12
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s1d[i] = (PAW + 1)'(r1_pa[i]) - (PAW + 1)'(r1_pb[i]);
            w_s2d[i] = (PBW + 1)'(r1_qa[i]) - (PBW + 1)'(r1_qb[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_o  <= r1_o;
            r2_d  <= r1_d;
            r2_e1 <= r1_e1;
            r2_e2 <= r1_e2;
            r2_s  <= r1_s;
            for (int i = 0; i < 3; i++) begin
                r2_s1[i] <= S1W'(w_s1d[i] >>> rti_pkg::PROD_SHIFT);
                r2_s2[i] <= S2W'(w_s2d[i] >>> rti_pkg::PROD_SHIFT);
            end
        end
    end

    // stage 3: dot-product terms
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_o <= r2_o;
            r3_d <= r2_d;
            for (int i = 0; i < 3; i++) begin
                r3_det[i] <= r2_s1[i] * r2_e1[i];
                r3_nt[i]  <= r2_s2[i] * r2_e2[i];
                r3_nb[i]  <= r2_s1[i] * r2_s[i];
                r3_ng[i]  <= r2_s2[i] * r2_d[i];
            end
        end
    end

    // stage 4: determinant and numerators
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_o   <= r3_o;
            r4_d   <= r3_d;
            r4_det <= DW'(r3_det[0]) + DW'(r3_det[1]) + DW'(r3_det[2]);
            r4_nt  <= DW'(r3_nt[0]) + DW'(r3_nt[1]) + DW'(r3_nt[2]);
            r4_nb  <= DW'(r3_nb[0]) + DW'(r3_nb[1]) + DW'(r3_nb[2]);
            r4_ng  <= DW'(r3_ng[0]) + DW'(r3_ng[1]) + DW'(r3_ng[2]);
        end
    end

    // stage 5: negative determinant flips every sign
    assign w_neg = r4_det[DW-1];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_o   <= r4_o;
            r5_d   <= r4_d;
            r5_det <= w_neg ? -r4_det : r4_det;
            r5_nt  <= w_neg ? -r4_nt  : r4_nt;
            r5_nb  <= w_neg ? -r4_nb  : r4_nb;
            r5_ng  <= w_neg ? -r4_ng  : r4_ng;
        end
    end

    // stage 6: strict inside test on the integer numerators, t overflow check
    assign w_bg_sum = (DW + 1)'(r5_nb) + (DW + 1)'(r5_ng);
    assign w_hit    = (r5_det != '0) && (r5_nt > 0) && (r5_nb > 0) && (r5_ng > 0)
                   && (w_bg_sum < (DW + 1)'(r5_det));
    assign w_sat    = (DW + TF)'(r5_nt) >= ((DW + TF)'(r5_det) <<< TF);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_o   <= r5_o;
            r6_d   <= r5_d;
            r6_det <= r5_det;
            r6_nt  <= r5_nt;
            r6_nb  <= r5_nb;
            r6_ng  <= r5_ng;
        end
    end

    // divider start values; zero on a miss, or for t on an overflow, keeps the remainder from exceeding the divisor
    assign w_live = r6_ctl.hit && !r6_ctl.sat;
    assign o_ctl  = r6_ctl;
    assign o_den  = r6_det;
    assign o_o    = r6_o;
    assign o_d    = r6_d;

    always_comb begin
        o_rem[0] = w_live ? (r6_nt >> TF) : '0;
        o_quo[0] = w_live ? {r6_nt[TF-1:0], {(QW - TF){1'b0}}} : '0;
        o_rem[1] = r6_ctl.hit ? r6_nb : '0;
        o_quo[1] = '0;
        o_rem[2] = r6_ctl.hit ? r6_ng : '0;
        o_quo[2] = '0;
    end

endmodule

`default_nettype wire

### rtl/core/rti_div_pipe.sv
// Pipelined restoring divider: three quotients over one divisor, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module rti_div_pipe #(
    parameter int DIV_WIDTH = 54,
    parameter int SB_WIDTH  = 120
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire rti_pkg::t_stage_ctl        i_ctl,
    input  wire logic [DIV_WIDTH-1:0]       i_den,
    input  wire logic [DIV_WIDTH-1:0]       i_rem [3],
    input  wire logic [rti_pkg::Q_WIDTH-1:0] i_quo [3],
    input  wire logic [SB_WIDTH-1:0]        i_sb,
    output rti_pkg::t_stage_ctl             o_ctl,
    output logic [rti_pkg::Q_WIDTH-1:0]     o_quo [3],
    output logic [SB_WIDTH-1:0]             o_sb
);

    localparam int NS = rti_pkg::Q_WIDTH;
    localparam int DW = DIV_WIDTH;

    rti_pkg::t_stage_ctl r_ctl [NS];
    logic [DW-1:0]       r_den [NS];
    logic [DW-1:0]       r_rem [NS][3];
    logic [NS-1:0]       r_quo [NS][3];
    logic [SB_WIDTH-1:0] r_sb  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        rti_pkg::t_stage_ctl c_in;
        logic [DW-1:0]       den_in;
        logic [DW-1:0]       rem_in [3];
        logic [NS-1:0]       quo_in [3];
        logic [SB_WIDTH-1:0] sb_in;
        logic [DW:0]         trial  [3];
        logic [DW-1:0]       n_rem  [3];
        logic [NS-1:0]       n_quo  [3];

        if (k == 0) begin : g_first
            assign c_in   = i_ctl;
            assign den_in = i_den;
            assign rem_in = i_rem;
            assign quo_in = i_quo;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign c_in   = r_ctl[k-1];
            assign den_in = r_den[k-1];
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign sb_in  = r_sb[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb begin
            for (int j = 0; j < 3; j++) begin
                trial[j] = {rem_in[j], quo_in[j][NS-1]};
                if (trial[j] >= {1'b0, den_in}) begin
                    n_rem[j] = DW'(trial[j] - {1'b0, den_in});
                    n_quo[j] = {quo_in[j][NS-2:0], 1'b1};
                end else begin
                    n_rem[j] = trial[j][DW-1:0];
                    n_quo[j] = {quo_in[j][NS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_adv) begin
                r_ctl[k] <= c_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_den[k] <= den_in;
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_sb[k]  <= sb_in;
            end
        end
    end

    assign o_ctl = r_ctl[NS-1];
    assign o_quo = r_quo[NS-1];
    assign o_sb  = r_sb[NS-1];

endmodule

`default_nettype wire

### rtl/core/rti_back.sv
// Back pipeline: weights, hit point, interpolated normal and texture, saturation.
`timescale 1ns / 1ps
`default_nettype none

module rti_back #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
    parameter int UV_WIDTH    = rti_pkg::UV_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire rti_pkg::t_stage_ctl           i_ctl,
    input  wire logic [rti_pkg::Q_WIDTH-1:0]   i_quo [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_o  [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_d  [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_na [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_nb [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_nc [3],
    input  wire logic [UV_WIDTH-1:0]           i_uv [6],
    output logic                               o_valid,
    output logic                               o_hit,
    output logic [rti_pkg::T_WIDTH-1:0]        o_hit_dist,
    output logic signed [COORD_WIDTH-1:0]      o_point  [3],
    output logic signed [COORD_WIDTH-1:0]      o_normal [3],
    output logic [UV_WIDTH-1:0]                o_tex    [2]
);

    localparam int CW  = COORD_WIDTH;
    localparam int UW  = UV_WIDTH;
    localparam int TW  = rti_pkg::T_WIDTH;
    localparam int WA  = rti_pkg::WA_WIDTH;
    localparam int WF  = rti_pkg::WEIGHT_FRAC;
    localparam int TF  = rti_pkg::T_FRAC;
    localparam int PTW = TW + 1 + CW;
    localparam int PNW = WA + 1 + CW;
    localparam int PUW = WA + UW;
    localparam int SPW = PTW - TF + 1;
    localparam int SNW = PNW + 2 - WF;
    localparam int SUW = PUW + 2 - WF;

    localparam logic signed [SPW-1:0] P_HI = SPW'(2 ** (CW - 1) - 1);
    localparam logic signed [SPW-1:0] P_LO = -P_HI - 1;
    localparam logic signed [SNW-1:0] N_HI = SNW'(2 ** (CW - 1) - 1);
    localparam logic signed [SNW-1:0] N_LO = -N_HI - 1;
    localparam logic [SUW-1:0]        U_MAX = {{(SUW - UW){1'b0}}, {UW{1'b1}}};

    // stage 0: t and the three weights
    rti_pkg::t_stage_ctl  r0_ctl;
    logic [TW-1:0]        r0_t;
    logic [WA-1:0]        r0_w [3];
    logic signed [CW-1:0] r0_o [3], r0_d [3];
    logic [WA-1:0]        w_wb, w_wg, w_wa;

    // stage 1: products
    rti_pkg::t_stage_ctl   r1_ctl;
    logic [TW-1:0]         r1_t;
    logic signed [CW-1:0]  r1_o [3];
    logic signed [PTW-1:0] r1_pt [3];
    logic signed [PNW-1:0] r1_pn [3][3];
    logic [PUW-1:0]        r1_pu [2][3];

    // stage 2: sums, floored
    rti_pkg::t_stage_ctl   r2_ctl;
    logic [TW-1:0]         r2_t;
    logic signed [SPW-1:0] r2_p [3];
    logic signed [SNW-1:0] r2_n [3];
    logic [SUW-1:0]        r2_u [2];
    logic signed [PNW+1:0] w_nsum [3];
    logic [PUW+1:0]        w_usum [2];

    // stage 3: output word
    logic                 r3_valid, r3_hit;
    logic [TW-1:0]        r3_t;
    logic signed [CW-1:0] r3_p [3], r3_n [3];
    logic [UW-1:0]        r3_u [2];

    function automatic logic signed [CW-1:0] sat_point(input logic signed [SPW-1:0] x);
        if (x > P_HI) begin
            return CW'(P_HI);
        end else if (x < P_LO) begin
            return CW'(P_LO);
        end
        return CW'(x);
    endfunction

    function automatic logic signed [CW-1:0] sat_normal(input logic signed [SNW-1:0] x);
        if (x > N_HI) begin
            return CW'(N_HI);
        end else if (x < N_LO) begin
            return CW'(N_LO);
        end
        return CW'(x);
    endfunction

    // valid and flag bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl   <= '0;
            r1_ctl   <= '0;
            r2_ctl   <= '0;
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r0_ctl   <= i_ctl;
            r1_ctl   <= r0_ctl;
            r2_ctl   <= r1_ctl;
            r3_valid <= r2_ctl.valid;
        end
    end

    // stage 0: alpha closes the weights to exactly one
    assign w_wb = WA'(i_quo[1] >> rti_pkg::W_SHIFT);
    assign w_wg = WA'(i_quo[2] >> rti_pkg::W_SHIFT);
    assign w_wa = WA'(2 ** WF) - w_wb - w_wg;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_t    <= i_ctl.sat ? {TW{1'b1}} : TW'(i_quo[0]);
            r0_w[0] <= w_wa;
            r0_w[1] <= w_wb;
            r0_w[2] <= w_wg;
            r0_o    <= i_o;
            r0_d    <= i_d;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_t <= r0_t;
            r1_o <= r0_o;
            for (int i = 0; i < 3; i++) begin
                r1_pt[i]    <= $signed({1'b0, r0_t}) * r0_d[i];
                r1_pn[i][0] <= $signed({1'b0, r0_w[0]}) * i_na[i];
                r1_pn[i][1] <= $signed({1'b0, r0_w[1]}) * i_nb[i];
                r1_pn[i][2] <= $signed({1'b0, r0_w[2]}) * i_nc[i];
            end
            for (int k = 0; k < 2; k++) begin
                r1_pu[k][0] <= r0_w[0] * i_uv[k];
                r1_pu[k][1] <= r0_w[1] * i_uv[2 + k];
                r1_pu[k][2] <= r0_w[2] * i_uv[4 + k];
            end
        end
    end

    // stage 2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nsum[i] = (PNW + 2)'(r1_pn[i][0]) + (PNW + 2)'(r1_pn[i][1])
                      + (PNW + 2)'(r1_pn[i][2]);
        end
        for (int k = 0; k < 2; k++) begin
            w_usum[k] = (PUW + 2)'(r1_pu[k][0]) + (PUW + 2)'(r1_pu[k][1])
                      + (PUW + 2)'(r1_pu[k][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_t <= r1_t;
            for (int i = 0; i < 3; i++) begin
                r2_p[i] <= SPW'(r1_o[i]) + SPW'(r1_pt[i] >>> TF);
                r2_n[i] <= SNW'(w_nsum[i] >>> WF);
            end
            for (int k = 0; k < 2; k++) begin
                r2_u[k] <= SUW'(w_usum[k] >> WF);
            end
        end
    end

    // stage 3: saturate; a miss reports all zeros
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_hit <= r2_ctl.hit;
            r3_t   <= r2_ctl.hit ? r2_t : '0;
            for (int i = 0; i < 3; i++) begin
                r3_p[i] <= r2_ctl.hit ? sat_point(r2_p[i]) : '0;
                r3_n[i] <= r2_ctl.hit ? sat_normal(r2_n[i]) : '0;
            end
            for (int k = 0; k < 2; k++) begin
                if (!r2_ctl.hit) begin
                    r3_u[k] <= '0;
                end else if (r2_u[k] > U_MAX) begin
                    r3_u[k] <= {UW{1'b1}};
                end else begin
                    r3_u[k] <= UW'(r2_u[k]);
                end
            end
        end
    end

    assign o_valid    = r3_valid;
    assign o_hit      = r3_hit;
    assign o_hit_dist = r3_t;
    assign o_point    = r3_p;
    assign o_normal   = r3_n;
    assign o_tex      = r3_u;

endmodule

`default_nettype wire

### rtl/core/ray_triangle_intersect_unit.sv
// Top level of the pipelined ray/triangle intersector with its triangle registers.
`timescale 1ns / 1ps
`default_nettype none

// Tests one ray per clock while o_in_stall is low against the triangle held in
// the configuration registers (Moller-Trumbore in fixed point, both faces
// count). A ray is taken in every cycle in which o_in_stall is low; its result
// word passes through 7 stages of edge, cross, dot product and hit test, 32
// stages of the restoring divider that forms t and two barycentric weights one
// quotient bit per stage, and 4 stages of interpolation and saturation. A stall
// on the output while a result word is valid freezes the whole pipe. A miss
// gives a word with every field zero. Write the triangle only while the pipe
// holds no ray.
module ray_triangle_intersect_unit #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
    parameter int UV_WIDTH    = rti_pkg::UV_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // ray channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]   i_origin_x,
    input  wire logic signed [COORD_WIDTH-1:0]   i_origin_y,
    input  wire logic signed [COORD_WIDTH-1:0]   i_origin_z,
    input  wire logic signed [COORD_WIDTH-1:0]   i_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0]   i_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0]   i_dir_z,
    // configuration channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rti_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [rti_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_hit,
    output logic [rti_pkg::T_WIDTH-1:0]          o_hit_distance,
    output logic signed [COORD_WIDTH-1:0]        o_point_x,
    output logic signed [COORD_WIDTH-1:0]        o_point_y,
    output logic signed [COORD_WIDTH-1:0]        o_point_z,
    output logic signed [COORD_WIDTH-1:0]        o_normal_x,
    output logic signed [COORD_WIDTH-1:0]        o_normal_y,
    output logic signed [COORD_WIDTH-1:0]        o_normal_z,
    output logic [UV_WIDTH-1:0]                  o_tex_u,
    output logic [UV_WIDTH-1:0]                  o_tex_v
);

    localparam int CW   = COORD_WIDTH;
    localparam int UW   = UV_WIDTH;
    localparam int DW   = rti_pkg::dot_width(COORD_WIDTH);
    localparam int SBW  = 6 * CW;
    localparam int VRW  = rti_pkg::VTX_REG_W;
    localparam int QW   = rti_pkg::Q_WIDTH;

    // triangle registers
    logic [VRW-1:0]               r_vtx [3];
    logic [VRW-1:0]               r_nrm [3];
    logic [rti_pkg::TEX_AB_W-1:0] r_tex_ab;
    logic [rti_pkg::TEX_C_W-1:0]  r_tex_c;

    logic signed [CW-1:0] w_vtx [3][3];
    logic signed [CW-1:0] w_nrm [3][3];
    logic [UW-1:0]        w_uv  [6];

    logic                 w_adv;
    logic signed [CW-1:0] w_in_o [3], w_in_d [3];

    rti_pkg::t_stage_ctl  w_f_ctl, w_v_ctl;
    logic [DW-1:0]        w_den;
    logic [DW-1:0]        w_rem [3];
    logic [QW-1:0]        w_quo_in [3], w_quo [3];
    logic signed [CW-1:0] w_f_o [3], w_f_d [3], w_v_o [3], w_v_d [3];
    logic [SBW-1:0]       w_sb_in, w_sb;

    logic signed [CW-1:0] w_point [3], w_normal [3];
    logic [UW-1:0]        w_tex [2];

    // register writes; the channel is always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx    <= '{default: '0};
            r_nrm    <= '{default: '0};
            r_tex_ab <= '0;
            r_tex_c  <= '0;
        end else if (i_cfg_valid) begin
            case (rti_pkg::t_cfg_index'(i_cfg_index))
                rti_pkg::CFG_VERTEX_A:    r_vtx[0] <= i_cfg_data[VRW-1:0];
                rti_pkg::CFG_VERTEX_B:    r_vtx[1] <= i_cfg_data[VRW-1:0];
                rti_pkg::CFG_VERTEX_C:    r_vtx[2] <= i_cfg_data[VRW-1:0];
                rti_pkg::CFG_NORMAL_A:    r_nrm[0] <= i_cfg_data[VRW-1:0];
                rti_pkg::CFG_NORMAL_B:    r_nrm[1] <= i_cfg_data[VRW-1:0];
                rti_pkg::CFG_NORMAL_C:    r_nrm[2] <= i_cfg_data[VRW-1:0];
                rti_pkg::CFG_TEXCOORD_AB: r_tex_ab <= i_cfg_data[rti_pkg::TEX_AB_W-1:0];
                rti_pkg::CFG_TEXCOORD_C:  r_tex_c  <= i_cfg_data[rti_pkg::TEX_C_W-1:0];
                default: ;
            endcase
        end
    end

    // field unpacking; fields past the register's top read as zero
    always_comb begin
        logic [VRW+3*CW-1:0]               ext_v, ext_m;
        logic [rti_pkg::TEX_AB_W+4*UW-1:0] ext_ab;
        logic [rti_pkg::TEX_C_W+2*UW-1:0]  ext_c;
        for (int r = 0; r < 3; r++) begin
            ext_v = {{(3 * CW){1'b0}}, r_vtx[r]};
            ext_m = {{(3 * CW){1'b0}}, r_nrm[r]};
            for (int i = 0; i < 3; i++) begin
                w_vtx[r][i] = ext_v[i*CW +: CW];
                w_nrm[r][i] = ext_m[i*CW +: CW];
            end
        end
        ext_ab = {{(4 * UW){1'b0}}, r_tex_ab};
        ext_c  = {{(2 * UW){1'b0}}, r_tex_c};
        for (int i = 0; i < 4; i++) begin
            w_uv[i] = ext_ab[i*UW +: UW];
        end
        w_uv[4] = ext_c[0 +: UW];
        w_uv[5] = ext_c[UW +: UW];
    end

    // the whole pipe moves unless a finished word is held by the output stall
    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    assign w_in_o[0] = i_origin_x;
    assign w_in_o[1] = i_origin_y;
    assign w_in_o[2] = i_origin_z;
    assign w_in_d[0] = i_dir_x;
    assign w_in_d[1] = i_dir_y;
    assign w_in_d[2] = i_dir_z;

    rti_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in_valid),
        .i_o     (w_in_o),
        .i_d     (w_in_d),
        .i_va    (w_vtx[0]),
        .i_vb    (w_vtx[1]),
        .i_vc    (w_vtx[2]),
        .o_ctl   (w_f_ctl),
        .o_den   (w_den),
        .o_rem   (w_rem),
        .o_quo   (w_quo_in),
        .o_o     (w_f_o),
        .o_d     (w_f_d)
    );

    // origin and direction ride beside the divider
    assign w_sb_in = {w_f_o[2], w_f_o[1], w_f_o[0], w_f_d[2], w_f_d[1], w_f_d[0]};

    rti_div_pipe #(
        .DIV_WIDTH (DW),
        .SB_WIDTH  (SBW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (w_f_ctl),
        .i_den   (w_den),
        .i_rem   (w_rem),
        .i_quo   (w_quo_in),
        .i_sb    (w_sb_in),
        .o_ctl   (w_v_ctl),
        .o_quo   (w_quo),
        .o_sb    (w_sb)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v_d[i] = w_sb[i*CW +: CW];
            w_v_o[i] = w_sb[(3 + i)*CW +: CW];
        end
    end

    rti_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .UV_WIDTH    (UV_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_ctl      (w_v_ctl),
        .i_quo      (w_quo),
        .i_o        (w_v_o),
        .i_d        (w_v_d),
        .i_na       (w_nrm[0]),
        .i_nb       (w_nrm[1]),
        .i_nc       (w_nrm[2]),
        .i_uv       (w_uv),
        .o_valid    (o_out_valid),
        .o_hit      (o_hit),
        .o_hit_dist (o_hit_distance),
        .o_point    (w_point),
        .o_normal   (w_normal),
        .o_tex      (w_tex)
    );

    assign o_point_x  = w_point[0];
    assign o_point_y  = w_point[1];
    assign o_point_z  = w_point[2];
    assign o_normal_x = w_normal[0];
    assign o_normal_y = w_normal[1];
    assign o_normal_z = w_normal[2];
    assign o_tex_u    = w_tex[0];
    assign o_tex_v    = w_tex[1];

endmodule

`default_nettype wire
